@@ hdl/tetra_dihedral_angle_core_defines.svh @@
// ----------------------------------------------------------------------------
// tetra_dihedral_angle_core_defines
// assertion macros used by the checker file of the dihedral angle core
// ----------------------------------------------------------------------------
`ifndef TETRA_DIHEDRAL_ANGLE_CORE_DEFINES_SVH
`define TETRA_DIHEDRAL_ANGLE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define TDA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet while arst_n is low
`define TDA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tda_pkg.sv @@
// ----------------------------------------------------------------------------
// tda_pkg
// widths, sideband type and arc tangent table of the dihedral angle core
// ----------------------------------------------------------------------------
package tda_pkg;

	// field widths
	localparam int COORD_W = 20;
	localparam int ANGLE_W = 16;

	// edge vectors: exact differences, then magnitudes kept below 2^30
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DH_W    = $clog2(DIFF_W);
	localparam int SHR_LIM = 30;
	localparam int VM_W    = (COORD_W < SHR_LIM) ? COORD_W : SHR_LIM;
	localparam int V_W     = VM_W + 1;

	// face normals before and after scaling
	localparam int N_W    = 2 * V_W;
	localparam int NM_W   = N_W - 1;
	localparam int NH_W   = $clog2(NM_W);
	localparam int NRM_SH = 30;
	localparam int NRM_W  = NRM_SH + 1;

	// cross and dot of the normals
	localparam int PC_W   = 2 * NRM_W;
	localparam int CD_W   = 63;
	localparam int CDM_W  = 62;
	localparam int CDH_W  = 6;
	localparam int CD_LIM = 31;
	localparam int SM_W   = 31;
	localparam int S_W    = 32;
	localparam int SQR_W  = 2 * SM_W;
	localparam int SQ_W   = 64;

	// square root
	localparam int RT_W  = SQ_W / 2;
	localparam int REM_W = RT_W + 3;

	// cordic
	localparam int C_W      = 44;
	localparam int C_PRE    = 8;
	localparam int Z_W      = 32;
	localparam int ZFRAC    = 30;
	localparam int CORDIC_N = 28;

	localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1) << (ZFRAC - 1);
	localparam logic signed [Z_W-1:0] Z_FULL = Z_W'(1) << ZFRAC;

	// atan(2^-i) in units of pi / 2^30
	localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_N] = '{
		32'sd268435456, 32'sd158466703, 32'sd83729454, 32'sd42502378,
		32'sd21333666,  32'sd10677233,  32'sd5339919,  32'sd2670123,
		32'sd1335082,   32'sd667543,    32'sd333772,   32'sd166886,
		32'sd83443,     32'sd41722,     32'sd20861,    32'sd10430,
		32'sd5215,      32'sd2608,      32'sd1304,     32'sd652,
		32'sd326,       32'sd163,       32'sd81,       32'sd41,
		32'sd20,        32'sd10,        32'sd5,        32'sd3
	};

	// what travels beside the radicand and the root
	typedef struct packed {
		logic                  degen;
		logic signed [S_W-1:0] x;
	} side_t;

endpackage

@@ hdl/tda_vert_if.sv @@
// ----------------------------------------------------------------------------
// tda_vert_if
// input channel: the four vertices of one tetrahedron per beat
// ----------------------------------------------------------------------------
interface tda_vert_if import tda_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] p0_x;
	logic signed [COORD_W-1:0] p0_y;
	logic signed [COORD_W-1:0] p0_z;
	logic signed [COORD_W-1:0] p1_x;
	logic signed [COORD_W-1:0] p1_y;
	logic signed [COORD_W-1:0] p1_z;
	logic signed [COORD_W-1:0] p2_x;
	logic signed [COORD_W-1:0] p2_y;
	logic signed [COORD_W-1:0] p2_z;
	logic signed [COORD_W-1:0] p3_x;
	logic signed [COORD_W-1:0] p3_y;
	logic signed [COORD_W-1:0] p3_z;

	modport source (
		output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
		input  ready
	);
	modport sink (
		input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
		input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
		output ready
	);
endinterface

@@ hdl/tda_res_if.sv @@
// ----------------------------------------------------------------------------
// tda_res_if
// result channel: one dihedral angle and its degenerate flag per beat
// ----------------------------------------------------------------------------
interface tda_res_if import tda_pkg::*;;
	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;
	logic               degenerate;

	modport source (output valid, angle, degenerate, input ready);
	modport sink (input valid, angle, degenerate, output ready);
endinterface

@@ hdl/tetra_dihedral_angle_core.sv @@
// ----------------------------------------------------------------------------
// tetra_dihedral_angle_core
// dihedral angle of a tetrahedron along edge p0-p1, fully pipelined
// ----------------------------------------------------------------------------
// One vertex set is taken per clock while the skid beat is free, and the
// pipeline depth up to its result comes from the 32-stage square root
// (one root bit a stage) and the 28-stage cordic (one rotation a stage),
// plus geometry, scaling and output stages. The output register is backed
// by one skid beat, so the input keeps taking beats while a result waits,
// and input ready drops only once both hold a beat. Angles are unsigned,
// all ones meaning pi; a zero-length edge or a flat face gives degenerate
// set and angle zero.
// ----------------------------------------------------------------------------
module tetra_dihedral_angle_core import tda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tda_vert_if.sink  vtx,
	tda_res_if.source res
);

	logic signed [COORD_W-1:0] pt [4][3];
	logic                      en;
	logic                      g_vld, p_vld, q_vld, c_vld;
	logic signed [NRM_W-1:0]   nrm [2][3];
	logic                      g_degen;
	logic [SQ_W-1:0]           rad;
	side_t                     p_side, q_side;
	logic [RT_W-1:0]           root;
	logic [ANGLE_W-1:0]        c_angle;
	logic                      c_degen;
	logic                      push, pop;
	logic                      out_vld_q, sk_vld_q;
	logic [ANGLE_W-1:0]        out_angle_q, sk_angle_q;
	logic                      out_degen_q, sk_degen_q;

	// vertex fields into an array
	assign pt[0][0] = vtx.p0_x;
	assign pt[0][1] = vtx.p0_y;
	assign pt[0][2] = vtx.p0_z;
	assign pt[1][0] = vtx.p1_x;
	assign pt[1][1] = vtx.p1_y;
	assign pt[1][2] = vtx.p1_z;
	assign pt[2][0] = vtx.p2_x;
	assign pt[2][1] = vtx.p2_y;
	assign pt[2][2] = vtx.p2_z;
	assign pt[3][0] = vtx.p3_x;
	assign pt[3][1] = vtx.p3_y;
	assign pt[3][2] = vtx.p3_z;

	// the whole pipeline moves unless the skid beat is occupied
	assign en        = ~sk_vld_q;
	assign vtx.ready = en;

	tda_geom u_geom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vtx.valid),
		.pt      (pt),
		.out_vld (g_vld),
		.nrm     (nrm),
		.degen   (g_degen)
	);

	tda_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (g_vld),
		.nrm     (nrm),
		.degen   (g_degen),
		.out_vld (p_vld),
		.rad     (rad),
		.side    (p_side)
	);

	tda_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (p_vld),
		.rad      (rad),
		.side_in  (p_side),
		.out_vld  (q_vld),
		.root     (root),
		.side_out (q_side)
	);

	tda_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (q_vld),
		.root    (root),
		.side_in (q_side),
		.out_vld (c_vld),
		.angle   (c_angle),
		.degen   (c_degen)
	);

	// output register with one skid beat behind it
	assign push = en & c_vld;
	assign pop  = out_vld_q & res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			sk_vld_q  <= 1'b0;
		end else if (!out_vld_q || pop) begin
			out_vld_q <= sk_vld_q | push;
			sk_vld_q  <= 1'b0;
		end else if (push) begin
			sk_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (sk_vld_q) begin
				out_angle_q <= sk_angle_q;
				out_degen_q <= sk_degen_q;
			end else begin
				out_angle_q <= c_angle;
				out_degen_q <= c_degen;
			end
		end else if (push) begin
			sk_angle_q <= c_angle;
			sk_degen_q <= c_degen;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.angle      = out_angle_q;
	assign res.degenerate = out_degen_q;

endmodule

@@ hdl/tda_geom.sv @@
// ----------------------------------------------------------------------------
// tda_geom
// edge vectors, face normals, degenerate test and normal scaling (6 stages)
// ----------------------------------------------------------------------------
module tda_geom import tda_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic signed [COORD_W-1:0] pt [4][3],
	output logic                      out_vld,
	output logic signed [NRM_W-1:0]   nrm [2][3],
	output logic                      degen
);

	function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] a);
		return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
	endfunction

	function automatic logic [N_W-1:0] abs_n(input logic signed [N_W-1:0] a);
		return a[N_W-1] ? N_W'(-a) : N_W'(a);
	endfunction

	function automatic logic [DH_W-1:0] top_d(input logic [DIFF_W-1:0] a);
		logic [DH_W-1:0] r;
		r = '0;
		for (int i = 0; i < DIFF_W; i++) if (a[i]) r = DH_W'(i);
		return r;
	endfunction

	function automatic logic [NH_W-1:0] top_n(input logic [NM_W-1:0] a);
		logic [NH_W-1:0] r;
		r = '0;
		for (int i = 0; i < NM_W; i++) if (a[i]) r = NH_W'(i);
		return r;
	endfunction

	logic                     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [DIFF_W-1:0] d_s1 [3][3];
	logic signed [V_W-1:0]    v_c [3][3];
	logic signed [V_W-1:0]    v_s2 [3][3];
	logic signed [N_W-1:0]    pr_s3 [2][6];
	logic signed [N_W-1:0]    n_s4 [2][3];
	logic [NM_W-1:0]          mag_c [2][3];
	logic [NH_W-1:0]          hi_c [2];
	logic                     degen_c;
	logic [NM_W-1:0]          mag_s5 [2][3];
	logic                     neg_s5 [2][3];
	logic [NH_W-1:0]          hi_s5 [2];
	logic                     degen_s5, degen_s6;
	logic signed [NRM_W-1:0]  nrm_c [2][3];
	logic signed [NRM_W-1:0]  nrm_s6 [2][3];

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// edge vectors bring magnitudes below 2^30, truncating toward zero
	always_comb begin
		logic [DIFF_W-1:0] m [3];
		logic [DIFF_W-1:0] o;
		logic [DH_W-1:0]   hi;
		logic [DH_W-1:0]   sh;
		logic [VM_W-1:0]   vm;
		for (int j = 0; j < 3; j++) begin
			o = '0;
			for (int k = 0; k < 3; k++) begin
				m[k] = abs_d(d_s1[j][k]);
				o    = o | m[k];
			end
			hi = top_d(o);
			sh = (32'(hi) >= 32'(SHR_LIM)) ? DH_W'(32'(hi) - 32'(SHR_LIM - 1)) : '0;
			for (int k = 0; k < 3; k++) begin
				vm = VM_W'(m[k] >> sh);
				v_c[j][k] = d_s1[j][k][DIFF_W-1] ? -$signed({1'b0, vm}) : $signed({1'b0, vm});
			end
		end
	end

	// magnitudes, leading one and zero test of the normals
	always_comb begin
		logic [N_W-1:0]  a;
		logic [NM_W-1:0] o;
		logic            z [2];
		for (int j = 0; j < 2; j++) begin
			o = '0;
			for (int k = 0; k < 3; k++) begin
				a           = abs_n(n_s4[j][k]);
				mag_c[j][k] = a[NM_W-1:0];
				o           = o | a[NM_W-1:0];
			end
			hi_c[j] = top_n(o);
			z[j]    = ~|o;
		end
		degen_c = z[0] | z[1];
	end

	// scale each normal so that its largest magnitude sits in [2^29, 2^30)
	always_comb begin
		logic [NM_W+NRM_SH-1:0] wide;
		logic [NH_W:0]          sh;
		logic [NRM_SH-1:0]      nm;
		for (int j = 0; j < 2; j++) begin
			sh = {1'b0, hi_s5[j]} + (NH_W + 1)'(1);
			for (int k = 0; k < 3; k++) begin
				wide = {mag_s5[j][k], {NRM_SH{1'b0}}};
				nm   = NRM_SH'(wide >> sh);
				nrm_c[j][k] = neg_s5[j][k] ? -$signed({1'b0, nm}) : $signed({1'b0, nm});
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[0][k] <= DIFF_W'(pt[1][k]) - DIFF_W'(pt[0][k]);
				d_s1[1][k] <= DIFF_W'(pt[2][k]) - DIFF_W'(pt[0][k]);
				d_s1[2][k] <= DIFF_W'(pt[3][k]) - DIFF_W'(pt[0][k]);
			end
			v_s2 <= v_c;
			for (int j = 0; j < 2; j++) begin
				for (int c = 0; c < 3; c++) begin
					pr_s3[j][2*c]   <= N_W'(v_s2[0][(c+1)%3]) * N_W'(v_s2[j+1][(c+2)%3]);
					pr_s3[j][2*c+1] <= N_W'(v_s2[0][(c+2)%3]) * N_W'(v_s2[j+1][(c+1)%3]);
					n_s4[j][c]      <= pr_s3[j][2*c] - pr_s3[j][2*c+1];
					neg_s5[j][c]    <= n_s4[j][c][N_W-1];
				end
			end
			mag_s5   <= mag_c;
			hi_s5    <= hi_c;
			degen_s5 <= degen_c;
			nrm_s6   <= nrm_c;
			degen_s6 <= degen_s5;
		end
	end

	assign out_vld = vld_s6;
	assign nrm     = nrm_s6;
	assign degen   = degen_s6;

endmodule

@@ hdl/tda_prep.sv @@
// ----------------------------------------------------------------------------
// tda_prep
// cross and dot of the scaled normals, common shift, sum of squares (6 stages)
// ----------------------------------------------------------------------------
module tda_prep import tda_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [NRM_W-1:0] nrm [2][3],
	input  logic                    degen,
	output logic                    out_vld,
	output logic [SQ_W-1:0]         rad,
	output side_t                   side
);

	function automatic logic [CDH_W-1:0] top_c(input logic [CDM_W-1:0] a);
		logic [CDH_W-1:0] r;
		r = '0;
		for (int i = 0; i < CDM_W; i++) if (a[i]) r = CDH_W'(i);
		return r;
	endfunction

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                    dg_s1, dg_s2, dg_s3, dg_s4, dg_s5, dg_s6;
	logic signed [PC_W-1:0]  pc_s1 [9];
	logic signed [CD_W-1:0]  cd_s2 [4];
	logic [CDM_W-1:0]        mag_c [4];
	logic [CDH_W-1:0]        sh_c;
	logic [CDM_W-1:0]        mag_s3 [4];
	logic                    xneg_s3;
	logic [CDH_W-1:0]        sh_s3;
	logic [SM_W-1:0]         m_s4 [3];
	logic signed [S_W-1:0]   x_c;
	logic signed [S_W-1:0]   x_s4, x_s5, x_s6;
	logic [SQR_W-1:0]        sqr_s5 [3];
	logic [SQ_W-1:0]         rad_s6;

	// valid bits move with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// magnitudes and one shared shift that brings them below 2^31
	always_comb begin
		logic [CD_W-1:0]  a;
		logic [CDM_W-1:0] o;
		logic [CDH_W-1:0] hi;
		o = '0;
		for (int k = 0; k < 4; k++) begin
			a        = cd_s2[k][CD_W-1] ? CD_W'(-cd_s2[k]) : CD_W'(cd_s2[k]);
			mag_c[k] = a[CDM_W-1:0];
			o        = o | a[CDM_W-1:0];
		end
		hi   = top_c(o);
		sh_c = (hi >= CDH_W'(CD_LIM)) ? hi - CDH_W'(CD_LIM - 1) : '0;
	end

	// shifted dot product keeps its sign
	always_comb begin
		logic [SM_W-1:0] m;
		m   = SM_W'(mag_s3[3] >> sh_s3);
		x_c = xneg_s3 ? -$signed({1'b0, m}) : $signed({1'b0, m});
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pc_s1[2*c]   <= PC_W'(nrm[0][(c+1)%3]) * PC_W'(nrm[1][(c+2)%3]);
				pc_s1[2*c+1] <= PC_W'(nrm[0][(c+2)%3]) * PC_W'(nrm[1][(c+1)%3]);
				pc_s1[6+c]   <= PC_W'(nrm[0][c]) * PC_W'(nrm[1][c]);
				cd_s2[c]     <= CD_W'(pc_s1[2*c]) - CD_W'(pc_s1[2*c+1]);
				m_s4[c]      <= SM_W'(mag_s3[c] >> sh_s3);
				sqr_s5[c]    <= SQR_W'(m_s4[c]) * SQR_W'(m_s4[c]);
			end
			cd_s2[3] <= CD_W'(pc_s1[6]) + CD_W'(pc_s1[7]) + CD_W'(pc_s1[8]);
			mag_s3   <= mag_c;
			sh_s3    <= sh_c;
			xneg_s3  <= cd_s2[3][CD_W-1];
			x_s4     <= x_c;
			x_s5     <= x_s4;
			x_s6     <= x_s5;
			rad_s6   <= SQ_W'(sqr_s5[0]) + SQ_W'(sqr_s5[1]) + SQ_W'(sqr_s5[2]);
			dg_s1    <= degen;
			dg_s2    <= dg_s1;
			dg_s3    <= dg_s2;
			dg_s4    <= dg_s3;
			dg_s5    <= dg_s4;
			dg_s6    <= dg_s5;
		end
	end

	assign out_vld    = vld_s6;
	assign rad        = rad_s6;
	assign side.degen = dg_s6;
	assign side.x     = x_s6;

endmodule

@@ hdl/tda_isqrt.sv @@
// ----------------------------------------------------------------------------
// tda_isqrt
// floor square root, one result bit per stage (RT_W stages)
// ----------------------------------------------------------------------------
module tda_isqrt import tda_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [SQ_W-1:0] rad,
	input  side_t           side_in,
	output logic            out_vld,
	output logic [RT_W-1:0] root,
	output side_t           side_out
);

	logic             vld_s  [RT_W];
	logic [SQ_W-1:0]  rad_s  [RT_W];
	logic [REM_W-1:0] rem_s  [RT_W];
	logic [RT_W-1:0]  root_s [RT_W];
	side_t            side_s [RT_W];

	for (genvar i = 0; i < RT_W; i++) begin : g_step
		logic             pv;
		logic [SQ_W-1:0]  pr;
		logic [REM_W-1:0] prem;
		logic [RT_W-1:0]  proot;
		side_t            ps;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;

		// previous stage, or the incoming beat for the first one
		if (i == 0) begin : g_first
			assign pv    = in_vld;
			assign pr    = rad;
			assign prem  = '0;
			assign proot = '0;
			assign ps    = side_in;
		end else begin : g_next
			assign pv    = vld_s[i-1];
			assign pr    = rad_s[i-1];
			assign prem  = rem_s[i-1];
			assign proot = root_s[i-1];
			assign ps    = side_s[i-1];
		end

		// bring down the next two radicand bits and try the next root bit
		assign cur   = {prem[REM_W-3:0], pr[SQ_W-1 -: 2]};
		assign trial = REM_W'({proot, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]  <= pr << 2;
				side_s[i] <= ps;
				if (cur >= trial) begin
					rem_s[i]  <= cur - trial;
					root_s[i] <= {proot[RT_W-2:0], 1'b1};
				end else begin
					rem_s[i]  <= cur;
					root_s[i] <= {proot[RT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[RT_W-1];
	assign root     = root_s[RT_W-1];
	assign side_out = side_s[RT_W-1];

endmodule

@@ hdl/tda_cordic.sv @@
// ----------------------------------------------------------------------------
// tda_cordic
// quadrant fold, vectoring cordic for the angle, clamp and scale to full range
// ----------------------------------------------------------------------------
module tda_cordic import tda_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [RT_W-1:0]    root,
	input  side_t              side_in,
	output logic               out_vld,
	output logic [ANGLE_W-1:0] angle,
	output logic               degen
);

	localparam int ZP_W = ZFRAC + ANGLE_W + 2;

	logic                  vld_s [CORDIC_N+1];
	logic signed [C_W-1:0] x_s   [CORDIC_N+1];
	logic signed [C_W-1:0] y_s   [CORDIC_N+1];
	logic signed [Z_W-1:0] z_s   [CORDIC_N+1];
	logic                  dg_s  [CORDIC_N+1];
	logic                  fin_vld_s;
	logic [ANGLE_W-1:0]    fin_angle_s;
	logic                  fin_dg_s;
	logic signed [C_W-1:0] xn;
	logic signed [C_W-1:0] yr;
	logic [ZFRAC:0]        zc;
	logic [ZP_W-1:0]       prod;

	assign xn = C_W'(side_in.x);
	assign yr = $signed(C_W'({1'b0, root}));

	// obtuse side: rotate by a quarter turn so the start vector has x >= 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s[0] <= side_in.degen;
			if (side_in.x[S_W-1]) begin
				x_s[0] <= yr <<< C_PRE;
				y_s[0] <= (-xn) <<< C_PRE;
				z_s[0] <= Z_HALF;
			end else begin
				x_s[0] <= xn <<< C_PRE;
				y_s[0] <= yr <<< C_PRE;
				z_s[0] <= '0;
			end
		end
	end

	// one micro-rotation per stage, shifts are arithmetic
	for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
		logic signed [C_W-1:0] xs;
		logic signed [C_W-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dg_s[i+1] <= dg_s[i];
				if (y_s[i][C_W-1]) begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATAN_TAB[i];
				end else begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATAN_TAB[i];
				end
			end
		end
	end

	// clamp to [0, pi] and scale so that pi maps to all ones, rounded
	always_comb begin
		if (z_s[CORDIC_N][Z_W-1]) begin
			zc = '0;
		end else if (z_s[CORDIC_N] > Z_FULL) begin
			zc = (ZFRAC + 1)'(Z_FULL);
		end else begin
			zc = (ZFRAC + 1)'(z_s[CORDIC_N]);
		end
		prod = ZP_W'(zc) * ZP_W'({ANGLE_W{1'b1}}) + ZP_W'(Z_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s <= 1'b0;
		end else if (en) begin
			fin_vld_s <= vld_s[CORDIC_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_dg_s    <= dg_s[CORDIC_N];
			fin_angle_s <= dg_s[CORDIC_N] ? '0 : prod[ZFRAC +: ANGLE_W];
		end
	end

	assign out_vld = fin_vld_s;
	assign angle   = fin_angle_s;
	assign degen   = fin_dg_s;

endmodule

@@ hdl/tda_checker.sv @@
// ----------------------------------------------------------------------------
// tda_checker
// port-level checks of the dihedral angle core, bound to the top level
// ----------------------------------------------------------------------------
`include "tetra_dihedral_angle_core_defines.svh"

module tda_checker import tda_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [ANGLE_W-1:0] angle,
	input logic               degenerate
);

	// a stalled result beat holds
	`TDA_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(angle) && $stable(degenerate), "result beat changed while stalled")

	// an empty output never holds back the input
	`TDA_ASSERT_IMP(a_idle_ready, !res_valid, in_ready, "input stalled with output empty")

	// input stalls only after the output itself was stalled
	`TDA_ASSERT_IMP(a_stall_cause, $fell(in_ready), $past(res_valid && !res_ready), "input stalled without output back-pressure")

	// a degenerate tetrahedron reports a zero angle
	`TDA_ASSERT_IMP(a_degen_zero, res_valid && degenerate, angle == '0, "degenerate result with nonzero angle")

	// an input beat waiting alone cannot be refused forever with output free
	`TDA_ASSERT_NXT(a_ready_back, in_valid && !in_ready && res_ready, in_ready, "input not released after output drained")

endmodule

bind tetra_dihedral_angle_core tda_checker u_tda_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vtx.valid),
	.in_ready   (vtx.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.angle      (res.angle),
	.degenerate (res.degenerate)
);

@@ tb/tda_angle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tda_angle_checker
// watches the vertex and result channels of the dihedral angle core, works
// out the angle of every accepted vertex set and compares it with the
// result beats in order
// ----------------------------------------------------------------------------
module tda_angle_checker import tda_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tda_vert_if  vtx,
	tda_res_if   res,
	output int   errors,
	output int   pending
);

	typedef longint vec4_t [4];

	typedef struct {
		logic [ANGLE_W-1:0] angle;
		logic               degenerate;
	} angle_res_t;

	angle_res_t angles_due [$];

	// magnitude of a signed value
	function automatic longint unsigned mag_of(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// right shift of magnitudes until each is below 2^lim, toward zero
	function automatic vec4_t scale_down(vec4_t v, int n, int lim);
		longint unsigned m;
		longint unsigned mk;
		int s;
		vec4_t r;
		m = 0;
		s = 0;
		r = v;
		for (int k = 0; k < n; k++) begin
			if (mag_of(v[k]) > m) m = mag_of(v[k]);
		end
		while ((m >> s) >= (64'd1 << lim)) s++;
		for (int k = 0; k < n; k++) begin
			mk = mag_of(v[k]) >> s;
			r[k] = (v[k] < 0) ? -longint'(mk) : longint'(mk);
		end
		return r;
	endfunction

	// nonzero normal: largest magnitude brought into [2^29, 2^30)
	function automatic vec4_t fit_normal(vec4_t v);
		longint unsigned m;
		longint unsigned mk;
		int s;
		vec4_t r;
		r = scale_down(v, 3, 30);
		m = 0;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			if (mag_of(r[k]) > m) m = mag_of(r[k]);
		end
		while ((m << s) < (64'd1 << 29)) s++;
		for (int k = 0; k < 3; k++) begin
			mk = mag_of(r[k]) << s;
			r[k] = (r[k] < 0) ? -longint'(mk) : longint'(mk);
		end
		return r;
	endfunction

	function automatic vec4_t cross_of(vec4_t a, vec4_t b);
		vec4_t r;
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
		r[3] = 0;
		return r;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned a);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > a) b >>= 2;
		while (b != 0) begin
			if (a >= r + b) begin
				a -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// dihedral angle along p0-p1 of one vertex set
	function automatic angle_res_t dihedral_of(vec4_t p0, vec4_t p1, vec4_t p2,
		vec4_t p3);
		vec4_t v1, v2, v3, n2, n3, cd;
		longint unsigned sq;
		longint x, y, z, t, xs, ys;
		angle_res_t r;
		for (int k = 0; k < 3; k++) begin
			v1[k] = p1[k] - p0[k];
			v2[k] = p2[k] - p0[k];
			v3[k] = p3[k] - p0[k];
		end
		v1 = scale_down(v1, 3, 30);
		v2 = scale_down(v2, 3, 30);
		v3 = scale_down(v3, 3, 30);
		n2 = cross_of(v1, v2);
		n3 = cross_of(v1, v3);
		if ((n2[0] == 0 && n2[1] == 0 && n2[2] == 0) ||
			(n3[0] == 0 && n3[1] == 0 && n3[2] == 0)) begin
			r.angle = '0;
			r.degenerate = 1'b1;
			return r;
		end
		n2 = fit_normal(n2);
		n3 = fit_normal(n3);
		cd = cross_of(n2, n3);
		cd[3] = n2[0] * n3[0] + n2[1] * n3[1] + n2[2] * n3[2];
		cd = scale_down(cd, 4, 31);
		sq = longint'(cd[0] * cd[0]) + longint'(cd[1] * cd[1]) + longint'(cd[2] * cd[2]);
		y = longint'(root_floor(sq));
		x = cd[3];
		z = 0;
		// obtuse: rotate by a quarter turn first
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = longint'(1) << (ZFRAC - 1);
		end
		x = x * 256;
		y = y * 256;
		for (int k = 0; k < CORDIC_N; k++) begin
			xs = x >>> k;
			ys = y >>> k;
			if (y < 0) begin
				x -= ys;
				y += xs;
				z -= longint'(ATAN_TAB[k]);
			end else begin
				x += ys;
				y -= xs;
				z += longint'(ATAN_TAB[k]);
			end
		end
		if (z < 0) z = 0;
		if (z > (longint'(1) << ZFRAC)) z = longint'(1) << ZFRAC;
		r.angle = ANGLE_W'((z * ((longint'(1) << ANGLE_W) - 1) +
			(longint'(1) << (ZFRAC - 1))) >> ZFRAC);
		r.degenerate = 1'b0;
		return r;
	endfunction

	assign pending = angles_due.size();

	// vertex beats in, result beats compared
	always @(posedge clk) begin
		vec4_t p0, p1, p2, p3;
		angle_res_t due;
		if (arst_n && vtx.valid && vtx.ready) begin
			p0 = '{longint'(vtx.p0_x), longint'(vtx.p0_y), longint'(vtx.p0_z), 0};
			p1 = '{longint'(vtx.p1_x), longint'(vtx.p1_y), longint'(vtx.p1_z), 0};
			p2 = '{longint'(vtx.p2_x), longint'(vtx.p2_y), longint'(vtx.p2_z), 0};
			p3 = '{longint'(vtx.p3_x), longint'(vtx.p3_y), longint'(vtx.p3_z), 0};
			angles_due.push_back(dihedral_of(p0, p1, p2, p3));
		end
		if (arst_n && res.valid && res.ready) begin
			if (angles_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: angle %0d degenerate %0b",
						res.angle, res.degenerate);
			end else begin
				due = angles_due.pop_front();
				if (res.angle !== due.angle || res.degenerate !== due.degenerate) begin
					errors++;
					if (errors <= 10)
						$display("result mismatch: expected angle %0d degenerate %0b, got angle %0d degenerate %0b",
							due.angle, due.degenerate, res.angle, res.degenerate);
				end
			end
		end
	end

	initial errors = 0;

endmodule

@@ tb/tetra_dihedral_angle_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tetra_dihedral_angle_core_tb
// drives directed and random tetrahedra into the dihedral angle core with
// random gaps and output stalls; a checker beside the core predicts every
// angle and counts mismatches, and this top gives the verdict
// ----------------------------------------------------------------------------
module tetra_dihedral_angle_core_tb;
	import tda_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t tet_t [12];

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   item_cnt;

	tda_vert_if vtx ();
	tda_res_if  res ();

	tetra_dihedral_angle_core dut (.clk(clk), .arst_n(arst_n), .vtx(vtx), .res(res));

	tda_angle_checker chk (
		.clk(clk), .arst_n(arst_n), .vtx(vtx), .res(res),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side back-pressure, quiet while the input side runs without gaps
	initial begin
		res.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (item_cnt >= 400 && item_cnt < 600)
				res.ready = 1'b1;
			else
				res.ready = ($urandom_range(0, 99) >= 21);
		end
	end

	// one vertex beat, after an occasional gap
	task automatic send_tet(tet_t t);
		if (!(item_cnt >= 400 && item_cnt < 600) && $urandom_range(0, 99) < 11) begin
			vtx.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		{vtx.p0_x, vtx.p0_y, vtx.p0_z} = {t[0], t[1], t[2]};
		{vtx.p1_x, vtx.p1_y, vtx.p1_z} = {t[3], t[4], t[5]};
		{vtx.p2_x, vtx.p2_y, vtx.p2_z} = {t[6], t[7], t[8]};
		{vtx.p3_x, vtx.p3_y, vtx.p3_z} = {t[9], t[10], t[11]};
		vtx.valid = 1'b1;
		do @(posedge clk); while (!vtx.ready);
		@(negedge clk);
		item_cnt++;
	endtask

	function automatic coord_t rnd_coord();
		return coord_t'($urandom);
	endfunction

	// random vertex set: wide, clustered or near-degenerate
	function automatic tet_t rnd_tet();
		tet_t t;
		int sel;
		int f;
		sel = $urandom_range(0, 99);
		for (int k = 0; k < 12; k++) t[k] = rnd_coord();
		if (sel >= 60 && sel < 85) begin
			for (int k = 3; k < 12; k++)
				t[k] = t[k % 3] + coord_t'($urandom_range(0, 128)) - coord_t'(64);
		end else if (sel >= 85) begin
			f = $urandom_range(0, 3);
			for (int k = 0; k < 3; k++) begin
				if (f == 0) t[3 + k] = t[k];
				else t[6 + k] = t[k] + coord_t'(f) * (t[3 + k] - t[k]);
			end
		end
		return t;
	endfunction

	initial begin
		tet_t directed [$];
		coord_t mx, mn;
		mx = coord_t'(524287);
		mn = coord_t'(-524288);
		vtx.valid = 1'b0;
		{vtx.p0_x, vtx.p0_y, vtx.p0_z, vtx.p1_x, vtx.p1_y, vtx.p1_z} = '0;
		{vtx.p2_x, vtx.p2_y, vtx.p2_z, vtx.p3_x, vtx.p3_y, vtx.p3_z} = '0;
		item_cnt = 0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// all at one point, then right, straight and zero angles
		directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		directed.push_back('{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, 0, 100});
		directed.push_back('{0, 0, 0, 100, 0, 0, 0, 100, 0, 0, -100, 0});
		directed.push_back('{0, 0, 0, 100, 0, 0, 0, 100, 7, 0, 100, 7});
		// flat face: p2 on the edge line
		directed.push_back('{0, 0, 0, 100, 0, 0, 300, 0, 0, 0, 0, 100});
		// zero-length edge
		directed.push_back('{5, 5, 5, 5, 5, 5, 0, 100, 0, 0, 0, 100});
		// obtuse, near pi, near zero
		directed.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, -1, 1});
		directed.push_back('{0, 0, 0, 1, 0, 0, 0, 1000, 0, 0, -1000, 1});
		directed.push_back('{0, 0, 0, 1, 0, 0, 0, 1000, 0, 0, 1000, 1});
		// field extremes
		directed.push_back('{mn, mn, mn, mx, mx, mx, mx, mn, 0, mn, mx, mx});
		directed.push_back('{mx, mx, mx, mn, mn, mn, mn, mx, mn, mx, mn, mx});
		directed.push_back('{mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mn});
		directed.push_back('{mn, 0, 0, mx, 0, 0, 0, mx, 0, 0, mn, mx});
		directed.push_back('{mx, mx, mx, mn, mn, mn, mx, mx, mx, mn, mn, mn});
		directed.push_back('{-1, -1, -1, 1, 1, 1, -1, 1, -1, 1, -1, -1});
		foreach (directed[i]) send_tet(directed[i]);

		repeat (1050) send_tet(rnd_tet());
		vtx.valid = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// overall time limit
	initial begin
		#400000;
		$display("Mismatches found");
		$finish;
	end

endmodule
